@@ design/csm_pkg.sv @@
// shared types and constants of the clock settings menu
package csm_pkg;

  // menu states, one-hot
  typedef enum logic [15:0] {
    ST_CLOCK       = 16'h0001,
    ST_MAIN        = 16'h0002,
    ST_HOUR        = 16'h0004,
    ST_MINUTE      = 16'h0008,
    ST_DAY         = 16'h0010,
    ST_MONTH       = 16'h0020,
    ST_YEAR        = 16'h0040,
    ST_ALARM       = 16'h0080,
    ST_AL_EN       = 16'h0100,
    ST_AL_HOUR     = 16'h0200,
    ST_AL_MIN      = 16'h0400,
    ST_H24         = 16'h0800,
    ST_BR_DAY      = 16'h1000,
    ST_BR_NIGHT    = 16'h2000,
    ST_WIFI        = 16'h4000,
    ST_WIFI_RESET  = 16'h8000
  } csm_state_e;

  // event codes
  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_UP     = 3'd1;
  localparam logic [2:0] CMD_DOWN   = 3'd2;
  localparam logic [2:0] CMD_SELECT = 3'd3;
  localparam logic [2:0] CMD_BACK   = 3'd4;

  // rtc write requests
  localparam logic [1:0] RTC_NONE = 2'd0;
  localparam logic [1:0] RTC_TIME = 2'd1;
  localparam logic [1:0] RTC_DATE = 2'd2;

  // field limits
  localparam logic [4:0]  DAY_MAX    = 5'd31;
  localparam logic [3:0]  MONTH_MAX  = 4'd12;
  localparam logic [11:0] YEAR_MIN   = 12'd2000;
  localparam logic [11:0] YEAR_MAX   = 12'd2099;
  localparam logic [3:0]  BRIGHT_MAX = 4'd15;

  localparam logic [15:0] IDLE_TIMEOUT_RESET = 16'd30000;

  // one input beat, second is not needed by the menu
  typedef struct packed {
    logic [2:0]  command;
    logic [4:0]  now_hour;
    logic [5:0]  now_minute;
    logic [4:0]  now_day;
    logic [3:0]  now_month;
    logic [11:0] now_year;
  } csm_item_t;

  // one result beat
  typedef struct packed {
    logic [3:0]  menu_state;
    logic [2:0]  menu_item;
    logic        alarm_slot;
    logic [4:0]  show_hour;
    logic [5:0]  show_minute;
    logic [4:0]  edit_day_out;
    logic [3:0]  edit_month_out;
    logic [11:0] edit_year_out;
    logic        edit_flag_out;
    logic [3:0]  brightness_out;
    logic [1:0]  rtc_write;
    logic        settings_saved;
  } csm_result_t;

  // complete menu state
  typedef struct packed {
    csm_state_e        cur_state;
    logic [2:0]        item_index;
    logic              slot_index;
    logic [4:0]        work_hour;
    logic [5:0]        work_minute;
    logic [4:0]        work_day;
    logic [3:0]        work_month;
    logic [11:0]       work_year;
    logic [31:0]       undo_date_time;
    logic [11:0]       work_alarm;
    logic [11:0]       undo_alarm;
    logic [1:0][11:0]  alarm_store;
    logic              hour24_flag;
    logic              hour24_work;
    logic [3:0]        bright_day_store;
    logic [3:0]        bright_night_store;
    logic [3:0]        bright_day_work;
    logic [3:0]        bright_night_work;
    logic [15:0]       idle_count;
  } csm_state_t;

  localparam csm_state_t STATE_RESET = '{
    cur_state:          ST_CLOCK,
    item_index:         3'd0,
    slot_index:         1'b0,
    work_hour:          5'd0,
    work_minute:        6'd0,
    work_day:           5'd1,
    work_month:         4'd1,
    work_year:          12'd2000,
    undo_date_time:     32'd0,
    work_alarm:         12'd0,
    undo_alarm:         12'd0,
    alarm_store:        24'd0,
    hour24_flag:        1'b0,
    hour24_work:        1'b0,
    bright_day_store:   4'd8,
    bright_night_store: 4'd2,
    bright_day_work:    4'd8,
    bright_night_work:  4'd2,
    idle_count:         16'd0
  };

endpackage

@@ design/clock_setting_menu_fsm_unit.sv @@
// top level of the clock settings menu: stream ports, input and result registers
//
// Each input beat on s_axis carries one button or tick event together with the
// current RTC time and date; each accepted beat gives exactly one result beat on
// m_axis with the menu state, the values being edited, an RTC write request and
// a settings-changed flag.
// The beat is held in an input register, the menu logic is combinational from
// that register into the result register, and m_axis is driven from the result
// register. One beat is taken every cycle as long as the receiver keeps up.
// When m_axis stalls, the result register holds its beat and the input register
// holds one more, after which s_axis_tready drops until the result is taken.
// The cfg channel writes the idle timeout in ticks; it is always ready and is to
// be written only while no beat is in flight.
// Reset puts the menu in clock view with all edit and stored settings at their
// defaults, the timeout at 30000 ticks and both stream registers empty.
module clock_setting_menu_fsm_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input events
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command[2:0], now_hour[7:3], now_minute[13:8], now_second[19:14],
  // now_day[24:20], now_month[28:25], now_year[40:29], zero[47:41]
  input  logic [47:0] s_axis_tdata,
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // menu_state[3:0], menu_item[6:4], alarm_slot[7], show_hour[12:8],
  // show_minute[18:13], edit_day_out[23:19], edit_month_out[27:24],
  // edit_year_out[39:28], edit_flag_out[40], brightness_out[44:41],
  // rtc_write[46:45], settings_saved[47]
  output logic [47:0] m_axis_tdata,
  // idle timeout register write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic                 in_valid_q;
  csm_pkg::csm_item_t   in_item_q;
  logic                 out_valid_q;
  csm_pkg::csm_result_t out_data_q;
  logic [15:0]          timeout_q;
  csm_pkg::csm_state_t  state_q;
  csm_pkg::csm_state_t  state_d;
  csm_pkg::csm_result_t result_d;
  csm_pkg::csm_item_t   item_d;
  logic                 advance;

  // handshake
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  // unpack the input beat
  always_comb begin
    item_d.command    = s_axis_tdata[2:0];
    item_d.now_hour   = s_axis_tdata[7:3];
    item_d.now_minute = s_axis_tdata[13:8];
    item_d.now_day    = s_axis_tdata[24:20];
    item_d.now_month  = s_axis_tdata[28:25];
    item_d.now_year   = s_axis_tdata[40:29];
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q <= item_d;
    end
  end

  // menu logic
  csm_step u_step (
    .state_i  (state_q),
    .item_i   (in_item_q),
    .timeout_i(timeout_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // menu state and timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= csm_pkg::STATE_RESET;
      timeout_q <= csm_pkg::IDLE_TIMEOUT_RESET;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      if (cfg_valid_i) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= result_d;
    end
  end

  // pack the result beat
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_data_q.settings_saved, out_data_q.rtc_write,
                          out_data_q.brightness_out, out_data_q.edit_flag_out,
                          out_data_q.edit_year_out, out_data_q.edit_month_out,
                          out_data_q.edit_day_out, out_data_q.show_minute,
                          out_data_q.show_hour, out_data_q.alarm_slot,
                          out_data_q.menu_item, out_data_q.menu_state};

endmodule

@@ design/csm_step.sv @@
// next-state and result logic of the clock settings menu for one event
module csm_step (
  input  csm_pkg::csm_state_t  state_i,
  input  csm_pkg::csm_item_t   item_i,
  input  logic [15:0]          timeout_i,
  output csm_pkg::csm_state_t  state_o,
  output csm_pkg::csm_result_t result_o
);

  // main menu entries
  localparam logic [2:0] MENU_TIME     = 3'd0;
  localparam logic [2:0] MENU_DATE     = 3'd1;
  localparam logic [2:0] MENU_ALARM    = 3'd2;
  localparam logic [2:0] MENU_H24      = 3'd3;
  localparam logic [2:0] MENU_BR_DAY   = 3'd4;
  localparam logic [2:0] MENU_BR_NIGHT = 3'd5;
  localparam logic [2:0] MENU_WIFI     = 3'd6;

  // fold a value below three times the modulus back into range
  function automatic logic [6:0] mod_fold(input logic [6:0] v, input logic [6:0] m);
    logic [6:0] r;
    r = v;
    if (r >= m) r = r - m;
    if (r >= m) r = r - m;
    return r;
  endfunction

  function automatic logic [4:0] hour_step(input logic [4:0] h, input logic up,
                                           input logic dn);
    logic [6:0] t;
    t = {2'b00, h};
    if (up) t = mod_fold(t + 7'd1, 7'd24);
    else if (dn) t = mod_fold(t + 7'd23, 7'd24);
    return t[4:0];
  endfunction

  function automatic logic [5:0] minute_step(input logic [5:0] m, input logic up,
                                             input logic dn);
    logic [6:0] t;
    t = {1'b0, m};
    if (up) t = mod_fold(t + 7'd1, 7'd60);
    else if (dn) t = mod_fold(t + 7'd59, 7'd60);
    return t[5:0];
  endfunction

  // day wraps 1..31, an underflow goes to the top
  function automatic logic [4:0] day_step(input logic [4:0] d, input logic up,
                                          input logic dn);
    logic [6:0] x;
    logic [4:0] r;
    x = {2'b00, d};
    if (up) x = x + 7'd1;
    if (dn) x = x - 7'd1;
    if (x[6] || x == 7'd0) r = csm_pkg::DAY_MAX;
    else if (x > {2'b00, csm_pkg::DAY_MAX}) r = 5'd1;
    else r = x[4:0];
    return r;
  endfunction

  // month wraps 1..12
  function automatic logic [3:0] month_step(input logic [3:0] m, input logic up,
                                            input logic dn);
    logic [5:0] x;
    logic [3:0] r;
    x = {2'b00, m};
    if (up) x = x + 6'd1;
    if (dn) x = x - 6'd1;
    if (x[5] || x == 6'd0) r = csm_pkg::MONTH_MAX;
    else if (x > {2'b00, csm_pkg::MONTH_MAX}) r = 4'd1;
    else r = x[3:0];
    return r;
  endfunction

  // year wraps 2000..2099, an underflow below zero counts as too large
  function automatic logic [11:0] year_step(input logic [11:0] y, input logic up,
                                            input logic dn);
    logic [13:0] x;
    logic [11:0] r;
    x = {2'b00, y};
    if (up) x = x + 14'd1;
    if (dn) x = x - 14'd1;
    if (x[13]) r = csm_pkg::YEAR_MIN;
    else if (x < {2'b00, csm_pkg::YEAR_MIN}) r = csm_pkg::YEAR_MAX;
    else if (x > {2'b00, csm_pkg::YEAR_MAX}) r = csm_pkg::YEAR_MIN;
    else r = x[11:0];
    return r;
  endfunction

  // brightness saturates at 1..15
  function automatic logic [3:0] bright_step(input logic [3:0] v, input logic up,
                                             input logic dn);
    logic [3:0] r;
    r = v;
    if (up && r != csm_pkg::BRIGHT_MAX) r = r + 4'd1;
    if (dn && r != 4'd0) r = r - 4'd1;
    if (r == 4'd0) r = 4'd1;
    return r;
  endfunction

  function automatic logic [3:0] state_code(input csm_pkg::csm_state_e s);
    logic [3:0] c;
    unique case (s)
      csm_pkg::ST_CLOCK:      c = 4'd0;
      csm_pkg::ST_MAIN:       c = 4'd1;
      csm_pkg::ST_HOUR:       c = 4'd2;
      csm_pkg::ST_MINUTE:     c = 4'd3;
      csm_pkg::ST_DAY:        c = 4'd4;
      csm_pkg::ST_MONTH:      c = 4'd5;
      csm_pkg::ST_YEAR:       c = 4'd6;
      csm_pkg::ST_ALARM:      c = 4'd7;
      csm_pkg::ST_AL_EN:      c = 4'd8;
      csm_pkg::ST_AL_HOUR:    c = 4'd9;
      csm_pkg::ST_AL_MIN:     c = 4'd10;
      csm_pkg::ST_H24:        c = 4'd11;
      csm_pkg::ST_BR_DAY:     c = 4'd12;
      csm_pkg::ST_BR_NIGHT:   c = 4'd13;
      csm_pkg::ST_WIFI:       c = 4'd14;
      csm_pkg::ST_WIFI_RESET: c = 4'd15;
      default:                c = 4'd0;
    endcase
    return c;
  endfunction

  logic        button;
  logic        ev_up;
  logic        ev_dn;
  logic        ev_sel;
  logic        ev_back;
  logic        timed_out;
  logic        in_alarm;
  logic [1:0]  rtc;
  logic        saved;
  logic [4:0]  al_h;
  logic [5:0]  al_m;
  logic [11:0] al_word;
  logic [11:0] al_stored;
  logic [3:0]  br;
  csm_pkg::csm_state_t n;

  // event decode, unknown codes act as ticks
  always_comb begin
    button  = (item_i.command == csm_pkg::CMD_UP) || (item_i.command == csm_pkg::CMD_DOWN) ||
              (item_i.command == csm_pkg::CMD_SELECT) || (item_i.command == csm_pkg::CMD_BACK);
    ev_up   = item_i.command == csm_pkg::CMD_UP;
    ev_dn   = item_i.command == csm_pkg::CMD_DOWN;
    ev_sel  = item_i.command == csm_pkg::CMD_SELECT;
    ev_back = item_i.command == csm_pkg::CMD_BACK;
  end

  // menu update
  always_comb begin
    n         = state_i;
    rtc       = csm_pkg::RTC_NONE;
    saved     = 1'b0;
    al_h      = state_i.work_alarm[4:0];
    al_m      = state_i.work_alarm[10:5];
    al_word   = state_i.work_alarm;
    al_stored = state_i.alarm_store[state_i.slot_index];
    br        = state_i.bright_day_work;

    // idle counter saturates, a button clears it
    if (button) n.idle_count = 16'd0;
    else if (state_i.idle_count != 16'hFFFF) n.idle_count = state_i.idle_count + 16'd1;

    timed_out = (state_i.cur_state != csm_pkg::ST_CLOCK) && (n.idle_count >= timeout_i);

    if (timed_out) begin
      n.cur_state = csm_pkg::ST_CLOCK;
    end else begin
      unique case (state_i.cur_state)
        csm_pkg::ST_CLOCK: begin
          if (ev_sel) begin
            n.item_index        = 3'd0;
            n.work_hour         = item_i.now_hour;
            n.work_minute       = item_i.now_minute;
            n.work_day          = item_i.now_day;
            n.work_month        = item_i.now_month;
            n.work_year         = item_i.now_year;
            n.undo_date_time    = {item_i.now_year, item_i.now_month, item_i.now_day,
                                   item_i.now_minute, item_i.now_hour};
            n.hour24_work       = state_i.hour24_flag;
            n.bright_day_work   = state_i.bright_day_store;
            n.bright_night_work = state_i.bright_night_store;
            n.cur_state         = csm_pkg::ST_MAIN;
          end
        end
        csm_pkg::ST_MAIN: begin
          if (ev_up) n.item_index = state_i.item_index + 3'd1;
          if (ev_dn) n.item_index = state_i.item_index - 3'd1;
          if (ev_back) n.cur_state = csm_pkg::ST_CLOCK;
          if (ev_sel) begin
            unique case (state_i.item_index)
              MENU_TIME:     n.cur_state = csm_pkg::ST_HOUR;
              MENU_DATE:     n.cur_state = csm_pkg::ST_DAY;
              MENU_ALARM: begin
                n.cur_state  = csm_pkg::ST_ALARM;
                n.slot_index = 1'b0;
              end
              MENU_H24:      n.cur_state = csm_pkg::ST_H24;
              MENU_BR_DAY:   n.cur_state = csm_pkg::ST_BR_DAY;
              MENU_BR_NIGHT: n.cur_state = csm_pkg::ST_BR_NIGHT;
              MENU_WIFI:     n.cur_state = csm_pkg::ST_WIFI;
              default:       n.cur_state = csm_pkg::ST_WIFI_RESET;
            endcase
          end
        end
        csm_pkg::ST_HOUR: begin
          n.work_hour = hour_step(state_i.work_hour, ev_up, ev_dn);
          if (ev_back) begin
            n.work_hour = state_i.undo_date_time[4:0];
            n.cur_state = csm_pkg::ST_MAIN;
          end
          if (ev_sel) n.cur_state = csm_pkg::ST_MINUTE;
        end
        csm_pkg::ST_MINUTE: begin
          n.work_minute = minute_step(state_i.work_minute, ev_up, ev_dn);
          if (ev_back) begin
            n.work_minute = state_i.undo_date_time[10:5];
            n.cur_state   = csm_pkg::ST_HOUR;
          end
          if (ev_sel) begin
            rtc         = csm_pkg::RTC_TIME;
            n.cur_state = csm_pkg::ST_MAIN;
          end
        end
        csm_pkg::ST_DAY: begin
          n.work_day = day_step(state_i.work_day, ev_up, ev_dn);
          if (ev_sel) n.cur_state = csm_pkg::ST_MONTH;
          if (ev_back) begin
            n.work_day  = state_i.undo_date_time[15:11];
            n.cur_state = csm_pkg::ST_MAIN;
          end
        end
        csm_pkg::ST_MONTH: begin
          n.work_month = month_step(state_i.work_month, ev_up, ev_dn);
          if (ev_sel) n.cur_state = csm_pkg::ST_YEAR;
          if (ev_back) begin
            n.work_month = state_i.undo_date_time[19:16];
            n.cur_state  = csm_pkg::ST_DAY;
          end
        end
        csm_pkg::ST_YEAR: begin
          n.work_year = year_step(state_i.work_year, ev_up, ev_dn);
          if (ev_sel) begin
            rtc         = csm_pkg::RTC_DATE;
            n.cur_state = csm_pkg::ST_MAIN;
          end
          if (ev_back) begin
            n.work_year = state_i.undo_date_time[31:20];
            n.cur_state = csm_pkg::ST_MONTH;
          end
        end
        csm_pkg::ST_ALARM: begin
          if (ev_up || ev_dn) n.slot_index = ~state_i.slot_index;
          if (ev_back) n.cur_state = csm_pkg::ST_MAIN;
          if (ev_sel) begin
            n.work_alarm = al_stored;
            n.undo_alarm = al_stored;
            n.cur_state  = csm_pkg::ST_AL_EN;
          end
        end
        csm_pkg::ST_AL_EN: begin
          if (ev_up || ev_dn) n.work_alarm[11] = ~state_i.work_alarm[11];
          if (ev_back) begin
            n.work_alarm[11] = state_i.undo_alarm[11];
            n.cur_state      = csm_pkg::ST_ALARM;
          end
          if (ev_sel) begin
            // only the enable bit is committed here
            if (al_stored[11] != state_i.work_alarm[11]) begin
              n.alarm_store[state_i.slot_index][11] = state_i.work_alarm[11];
              saved = 1'b1;
            end
            n.cur_state = csm_pkg::ST_AL_HOUR;
          end
        end
        csm_pkg::ST_AL_HOUR: begin
          al_h = hour_step(state_i.work_alarm[4:0], ev_up, ev_dn);
          if (ev_back) begin
            al_h        = state_i.undo_alarm[4:0];
            n.cur_state = csm_pkg::ST_AL_EN;
          end
          if (ev_sel) n.cur_state = csm_pkg::ST_AL_MIN;
          n.work_alarm[4:0] = al_h;
        end
        csm_pkg::ST_AL_MIN: begin
          al_m = minute_step(state_i.work_alarm[10:5], ev_up, ev_dn);
          if (ev_back) begin
            al_m        = state_i.undo_alarm[10:5];
            n.cur_state = csm_pkg::ST_AL_HOUR;
          end
          al_word      = {state_i.work_alarm[11], al_m, state_i.work_alarm[4:0]};
          n.work_alarm = al_word;
          if (ev_sel) begin
            if (al_stored != al_word) begin
              n.alarm_store[state_i.slot_index] = al_word;
              saved = 1'b1;
            end
            n.cur_state = csm_pkg::ST_MAIN;
          end
        end
        csm_pkg::ST_H24: begin
          if (ev_up || ev_dn) n.hour24_work = ~state_i.hour24_work;
          if (ev_sel) begin
            saved         = state_i.hour24_flag != state_i.hour24_work;
            n.hour24_flag = state_i.hour24_work;
            n.cur_state   = csm_pkg::ST_MAIN;
          end
          if (ev_back) begin
            n.hour24_work = state_i.hour24_flag;
            n.cur_state   = csm_pkg::ST_MAIN;
          end
        end
        csm_pkg::ST_BR_DAY: begin
          br                = bright_step(state_i.bright_day_work, ev_up, ev_dn);
          n.bright_day_work = br;
          if (ev_sel) begin
            saved              = state_i.bright_day_store != br;
            n.bright_day_store = br;
            n.cur_state        = csm_pkg::ST_MAIN;
          end
          if (ev_back) begin
            n.bright_day_work = state_i.bright_day_store;
            n.cur_state       = csm_pkg::ST_MAIN;
          end
        end
        csm_pkg::ST_BR_NIGHT: begin
          br                  = bright_step(state_i.bright_night_work, ev_up, ev_dn);
          n.bright_night_work = br;
          if (ev_sel) begin
            saved                = state_i.bright_night_store != br;
            n.bright_night_store = br;
            n.cur_state          = csm_pkg::ST_MAIN;
          end
          if (ev_back) begin
            n.bright_night_work = state_i.bright_night_store;
            n.cur_state         = csm_pkg::ST_MAIN;
          end
        end
        default: begin
          // wi-fi screens fall back to clock view
          n.cur_state = csm_pkg::ST_CLOCK;
        end
      endcase
    end
  end

  // result view of the new state
  always_comb begin
    in_alarm = (n.cur_state == csm_pkg::ST_AL_EN) || (n.cur_state == csm_pkg::ST_AL_HOUR) ||
               (n.cur_state == csm_pkg::ST_AL_MIN);
    result_o.menu_state     = state_code(n.cur_state);
    result_o.menu_item      = n.item_index;
    result_o.alarm_slot     = n.slot_index;
    result_o.show_hour      = in_alarm ? n.work_alarm[4:0] : n.work_hour;
    result_o.show_minute    = in_alarm ? n.work_alarm[10:5] : n.work_minute;
    result_o.edit_day_out   = n.work_day;
    result_o.edit_month_out = n.work_month;
    result_o.edit_year_out  = n.work_year;
    result_o.edit_flag_out  = in_alarm ? n.work_alarm[11] : n.hour24_work;
    result_o.brightness_out = (n.cur_state == csm_pkg::ST_BR_NIGHT) ?
                              n.bright_night_work : n.bright_day_work;
    result_o.rtc_write      = rtc;
    result_o.settings_saved = saved;
  end

  assign state_o = n;

endmodule
